// ===== rtl/core/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes and helpers for the stepper phase sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int STEP_BITS_DEFAULT = 16;
  localparam int WAIT_BITS         = 16;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int CFG_DATA_BITS     = 16;

  localparam logic [WAIT_BITS-1:0] WAIT_MAX = {WAIT_BITS{1'b1}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_WAIT     = 3'd0,
    REG_END_WAIT       = 3'd1,
    REG_PHASE_CONVERT  = 3'd2,
    REG_ROTATE_FORWARD = 3'd3,
    REG_ROTATE_REVERSE = 3'd4,
    REG_PIN_TABLE      = 3'd5,
    REG_MOTOR_MODES    = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_NONE       = 2'd0,
    CMD_POWER_ON   = 2'd1,
    CMD_POWER_DOWN = 2'd2
  } driver_cmd_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [WAIT_BITS-1:0] start_wait;
    logic [WAIT_BITS-1:0] end_wait;
    logic [7:0]           phase_convert;
    logic [7:0]           rotate_forward;
    logic [7:0]           rotate_reverse;
    logic [7:0]           pin_table;
    logic [3:0]           motor_modes;
  } cfg_t;

  typedef struct packed {
    logic       pin_a;
    logic       pin_b;
    logic       pins_drive;
    logic [1:0] driver_command;
    logic       channel_word;
    logic       focus_busy;
    logic       zoom_busy;
  } result_t;

  function automatic logic [1:0] entry2(input logic [7:0] tbl, input logic [1:0] idx);
    logic [7:0] sh;
    sh = tbl >> {idx, 1'b0};
    return sh[1:0];
  endfunction

  function automatic logic [WAIT_BITS-1:0] sat_inc(input logic [WAIT_BITS-1:0] v);
    return (v == WAIT_MAX) ? WAIT_MAX : v + 1'b1;
  endfunction

endpackage

// ===== rtl/core/sps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sps_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module sps_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output sps_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_wait     <= 16'd4;
      cfg.end_wait       <= 16'd4;
      cfg.phase_convert  <= 8'd27;
      cfg.rotate_forward <= 8'd228;
      cfg.rotate_reverse <= 8'd27;
      cfg.pin_table      <= 8'd156;
      cfg.motor_modes    <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sps_pkg::REG_START_WAIT:     cfg.start_wait     <= cfg_data;
        sps_pkg::REG_END_WAIT:       cfg.end_wait       <= cfg_data;
        sps_pkg::REG_PHASE_CONVERT:  cfg.phase_convert  <= cfg_data[7:0];
        sps_pkg::REG_ROTATE_FORWARD: cfg.rotate_forward <= cfg_data[7:0];
        sps_pkg::REG_ROTATE_REVERSE: cfg.rotate_reverse <= cfg_data[7:0];
        sps_pkg::REG_PIN_TABLE:      cfg.pin_table      <= cfg_data[7:0];
        sps_pkg::REG_MOTOR_MODES:    cfg.motor_modes    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/sps_core.sv =====
// ----------------------------------------------------------------------------
// sps_core
// Motor state registers and the combinational start/tick update.
// ----------------------------------------------------------------------------
module sps_core #(
  parameter int STEP_BITS = sps_pkg::STEP_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        opcode,
  input  logic                        motor_select,
  input  logic signed [STEP_BITS-1:0] step_count,
  input  sps_pkg::cfg_t               cfg,
  output sps_pkg::result_t            result
);

  localparam int WB = sps_pkg::WAIT_BITS;

  logic [WB-1:0]             start_counter, start_counter_next;
  logic [WB-1:0]             end_counter, end_counter_next;
  logic                      tick_enable, tick_enable_next;
  logic signed [STEP_BITS:0] remaining_steps [2];
  logic signed [STEP_BITS:0] remaining_steps_next [2];
  logic [2:0]                resume_phase [2];
  logic [2:0]                resume_phase_next [2];
  logic [1:0]                phase_accum [2];
  logic [1:0]                phase_accum_next [2];
  logic [1:0]                saved_pins [2];
  logic [1:0]                saved_pins_next [2];
  logic [1:0]                motor_busy, motor_busy_next;

  logic                      sel;
  logic                      sel_found;
  logic signed [STEP_BITS:0] s_ext;
  logic signed [STEP_BITS:0] r_cur;
  logic signed [STEP_BITS:0] r_new;
  logic                      pos;
  logic [1:0]                stage;
  logic [1:0]                tbl_idx;
  logic [1:0]                pins;
  logic                      rev;

  always_comb begin
    start_counter_next   = start_counter;
    end_counter_next     = end_counter;
    tick_enable_next     = tick_enable;
    remaining_steps_next = remaining_steps;
    resume_phase_next    = resume_phase;
    phase_accum_next     = phase_accum;
    saved_pins_next      = saved_pins;
    motor_busy_next      = motor_busy;
    result               = '0;

    s_ext     = {step_count[STEP_BITS-1], step_count};
    sel_found = (remaining_steps[0] != '0) || (remaining_steps[1] != '0);
    sel       = (remaining_steps[0] == '0);
    r_cur     = remaining_steps[sel];
    pos       = (r_cur > 0);
    stage     = (pos == resume_phase[sel][2]) ? resume_phase[sel][1:0]
                : sps_pkg::entry2(cfg.phase_convert, resume_phase[sel][1:0]);
    stage     = stage + phase_accum[sel];
    rev       = cfg.motor_modes[sel];
    tbl_idx   = sps_pkg::entry2((pos != rev) ? cfg.rotate_forward : cfg.rotate_reverse,
                                stage);
    pins      = sps_pkg::entry2(cfg.pin_table, tbl_idx);
    r_new     = pos ? r_cur - 1'b1 : r_cur + 1'b1;

    if (accept) begin
      if (opcode == sps_pkg::OP_START) begin
        if (step_count != '0) begin
          motor_busy_next[motor_select]      = 1'b1;
          result.pin_a                       = saved_pins[motor_select][0];
          result.pin_b                       = saved_pins[motor_select][1];
          result.pins_drive                  = 1'b1;
          result.driver_command              = sps_pkg::CMD_POWER_ON;
          result.channel_word                = cfg.motor_modes[2 + motor_select];
          phase_accum_next[motor_select]     = '0;
          remaining_steps_next[motor_select] = step_count[STEP_BITS-1] ? s_ext - 1'b1
                                                                       : s_ext + 1'b1;
          tick_enable_next                   = 1'b1;
        end
      end else if (tick_enable) begin
        start_counter_next = sps_pkg::sat_inc(start_counter);
        if (start_counter_next <= cfg.start_wait) begin
          end_counter_next = '0;
        end else if (!sel_found) begin
          tick_enable_next      = 1'b0;
          result.driver_command = sps_pkg::CMD_POWER_DOWN;
          motor_busy_next       = '0;
        end else if ((r_cur > 1) || (r_cur < -1)) begin
          phase_accum_next[sel]     = phase_accum[sel] + 1'b1;
          result.pin_a              = pins[0];
          result.pin_b              = pins[1];
          result.pins_drive         = 1'b1;
          remaining_steps_next[sel] = r_new;
          if ((r_new == 1) || (r_new == -1)) begin
            saved_pins_next[sel]   = pins;
            resume_phase_next[sel] = {(r_new == 1), stage + 1'b1};
          end
        end else begin
          end_counter_next = sps_pkg::sat_inc(end_counter);
          if (end_counter_next > cfg.end_wait) begin
            tick_enable_next          = 1'b0;
            remaining_steps_next[sel] = '0;
            result.driver_command     = sps_pkg::CMD_POWER_DOWN;
            motor_busy_next[sel]      = 1'b0;
            start_counter_next        = '0;
          end
        end
      end
    end

    result.focus_busy = motor_busy_next[0];
    result.zoom_busy  = motor_busy_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_counter   <= '0;
      end_counter     <= '0;
      tick_enable     <= 1'b0;
      remaining_steps <= '{default: '0};
      resume_phase    <= '{default: '0};
      phase_accum     <= '{default: '0};
      saved_pins      <= '{default: '0};
      motor_busy      <= '0;
    end else begin
      start_counter   <= start_counter_next;
      end_counter     <= end_counter_next;
      tick_enable     <= tick_enable_next;
      remaining_steps <= remaining_steps_next;
      resume_phase    <= resume_phase_next;
      phase_accum     <= phase_accum_next;
      saved_pins      <= saved_pins_next;
      motor_busy      <= motor_busy_next;
    end
  end

endmodule

// ===== rtl/core/sps_out_buf.sv =====
// ----------------------------------------------------------------------------
// sps_out_buf
// Result register with a skid entry so one more result is accepted under stall.
// ----------------------------------------------------------------------------
module sps_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sps_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output sps_pkg::result_t out_data
);

  logic             skid_valid;
  sps_pkg::result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== rtl/core/stepper_phase_sequencer.sv =====
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Two-motor (focus, zoom) stepper phase sequencer.
//
// Input channel (in_valid/in_stall): opcode 1 starts a move on motor_select
// with a signed step_count, opcode 0 is a step timer tick. Every input
// transaction yields exactly one result transaction on the output channel
// (out_valid/out_stall) carrying pin levels, pins_drive, driver_command,
// channel_word and both busy flags.
// Each result is registered in the output register, or in the skid entry
// under stall; one transaction is taken per cycle while in_stall is low.
// When the receiver stalls, one more result is held in a skid entry; in_stall
// rises only when that entry is full, and clears as the receiver drains.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and is to be written while the block is idle; unknown indexes are ignored.
// Synchronous reset loads the default tables and waits, clears all motor
// state, stops ticking and empties the output register.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer #(
  parameter int STEP_BITS = sps_pkg::STEP_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic                               motor_select,
  input  logic signed [STEP_BITS-1:0]        step_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               pin_a,
  output logic                               pin_b,
  output logic                               pins_drive,
  output logic [1:0]                         driver_command,
  output logic                               channel_word,
  output logic                               focus_busy,
  output logic                               zoom_busy,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  sps_pkg::cfg_t    cfg;
  sps_pkg::result_t core_result;
  sps_pkg::result_t out_data;
  logic             accept;
  logic             buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  sps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sps_core #(
    .STEP_BITS (STEP_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (opcode),
    .motor_select (motor_select),
    .step_count   (step_count),
    .cfg          (cfg),
    .result       (core_result)
  );

  sps_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign pin_a          = out_data.pin_a;
  assign pin_b          = out_data.pin_b;
  assign pins_drive     = out_data.pins_drive;
  assign driver_command = out_data.driver_command;
  assign channel_word   = out_data.channel_word;
  assign focus_busy     = out_data.focus_busy;
  assign zoom_busy      = out_data.zoom_busy;

endmodule
